@@ rtl/cmfr_pkg.sv @@
// Shared types, codes and tables for the companion MCU frame receiver.
package cmfr_pkg;

   localparam int FRAME_BUF_BYTES_DEF      = 20;
   localparam int TOUCH_SETTLE_SAMPLES_DEF = 10;

   localparam logic [7:0] START_BYTE  = 8'h02;
   localparam logic [2:0] MAX_RESULTS = 3'd6;
   localparam logic [3:0] TOUCH_TOP   = 4'hf;

   localparam logic [3:0] TYPE_VERSION   = 4'h0;
   localparam logic [3:0] TYPE_BUTTON    = 4'h2;
   localparam logic [3:0] TYPE_TOUCH     = 4'h3;
   localparam logic [3:0] TYPE_LED       = 4'h8;
   localparam logic [3:0] TYPE_BATTERY   = 4'h9;
   localparam logic [3:0] TYPE_BACKLIGHT = 4'hd;

   localparam logic [2:0] EV_KEY     = 3'd0;
   localparam logic [2:0] EV_BUTTON  = 3'd1;
   localparam logic [2:0] EV_TRACK   = 3'd2;
   localparam logic [2:0] EV_LIFT    = 3'd3;
   localparam logic [2:0] EV_BATTERY = 3'd4;
   localparam logic [2:0] EV_ACK     = 3'd5;
   localparam logic [2:0] EV_UNKNOWN = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOP,
      ST_WAIT0,
      ST_TEST0,
      ST_SCAN,
      ST_HDR,
      ST_SUM,
      ST_DECODE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        emit;
      logic [2:0]  kind;
      logic [15:0] key;
      logic [5:0]  mask;
      logic        rel;
      logic [15:0] x;
      logic [15:0] y;
      logic [3:0]  touch_next;
      logic        bat_load;
   } dec_type;

   // Rocker codes 6..9, portrait and landscape maps.
   function automatic logic [15:0] rocker_key(logic land, logic [1:0] sel);
      logic [15:0] r;
      r = 16'h0000;
      case ({land, sel})
         3'b000: r = 16'hf00e;
         3'b001: r = 16'hf012;
         3'b010: r = 16'hf011;
         3'b011: r = 16'h0080;
         3'b100: r = 16'hf012;
         3'b101: r = 16'h0080;
         3'b110: r = 16'hf00e;
         3'b111: r = 16'hf011;
         default: r = 16'h0000;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/cmfr_buf.sv @@
// Circular frame byte buffer with one write port and one registered read port.
module cmfr_buf #(
   parameter int N = cmfr_pkg::FRAME_BUF_BYTES_DEF
) (
   input  logic                       clock,
   input  logic [$clog2(N)-1:0]       head,
   input  logic                       wr_en,
   input  logic [$clog2(N+2)-1:0]     wr_off,
   input  logic [7:0]                 wr_data,
   input  logic [$clog2(N+2)-1:0]     rd_off,
   output logic [7:0]                 rd_data
);
   import cmfr_pkg::*;

   localparam int AW = $clog2(N);
   localparam int CW = $clog2(N + 2);

   logic [7:0]    buf_mem [N];
   logic [7:0]    rd_ff;
   logic [CW:0]   wsum;
   logic [CW:0]   rsum;
   logic [CW:0]   wfull;
   logic [CW:0]   rfull;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;

   // Map logical offset to a physical slot past the head.
   always_comb begin
      wsum  = (CW+1)'(head) + (CW+1)'(wr_off);
      rsum  = (CW+1)'(head) + (CW+1)'(rd_off);
      wfull = (wsum >= (CW+1)'(N)) ? wsum - (CW+1)'(N) : wsum;
      rfull = (rsum >= (CW+1)'(N)) ? rsum - (CW+1)'(N) : rsum;
      waddr = wfull[AW-1:0];
      raddr = rfull[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem[waddr] <= wr_data;
      end
      rd_ff <= buf_mem[raddr];
   end

   assign rd_data = rd_ff;

endmodule

@@ rtl/cmfr_decode.sv @@
// Event decoder for one checked frame.
module cmfr_decode #(
   parameter int SETTLE = cmfr_pkg::TOUCH_SETTLE_SAMPLES_DEF
) (
   input  logic [7:0]        hdr,
   input  logic [7:0]        p0,
   input  logic [7:0]        p1,
   input  logic [7:0]        p2,
   input  logic [7:0]        p3,
   input  logic              land,
   input  logic [3:0]        touch_cnt,
   output cmfr_pkg::dec_type dec
);
   import cmfr_pkg::*;

   localparam logic [3:0] SETTLE_CNT = 4'(SETTLE);

   logic [3:0]  mtype;
   logic [3:0]  mlen;
   logic [6:0]  code;
   logic        up;
   logic [15:0] a;
   logic [15:0] c;
   logic [2:0]  bit_sel;
   logic [1:0]  rock_sel;

   always_comb begin
      mtype    = hdr[7:4];
      mlen     = hdr[3:0];
      code     = p0[6:0];
      up       = p0[7];
      a        = {p0, p1};
      c        = {p2, p3};
      bit_sel  = (code == 7'd1) ? 3'd5 : 3'(code - 7'd1);
      rock_sel = 2'(code - 7'd6);

      dec            = '0;
      dec.touch_next = touch_cnt;
      case (mtype)
         TYPE_VERSION, TYPE_LED, TYPE_BACKLIGHT: begin
            dec.emit = 1'b1;
            dec.kind = EV_ACK;
         end
         TYPE_BUTTON: begin
            if (mlen != 4'd0) begin
               if (code > 7'd5) begin
                  if (code < 7'd10 && !up) begin
                     dec.emit = 1'b1;
                     dec.kind = EV_KEY;
                     dec.key  = rocker_key(land, rock_sel);
                  end
               end else if (code != 7'd0) begin
                  dec.emit = 1'b1;
                  dec.kind = EV_BUTTON;
                  dec.mask = 6'(1) << bit_sel;
                  dec.rel  = up;
               end
            end
         end
         TYPE_TOUCH: begin
            if (mlen == 4'd4) begin
               dec.touch_next = (touch_cnt < TOUCH_TOP) ? touch_cnt + 4'd1 : touch_cnt;
               if (touch_cnt > SETTLE_CNT) begin
                  dec.emit = 1'b1;
                  dec.kind = EV_TRACK;
                  dec.x    = land ? a : c;
                  dec.y    = land ? c : a;
               end
            end else begin
               dec.touch_next = 4'd0;
               dec.emit       = 1'b1;
               dec.kind       = EV_LIFT;
            end
         end
         TYPE_BATTERY: begin
            dec.bat_load = (mlen >= 4'd5);
            dec.emit     = 1'b1;
            dec.kind     = EV_BATTERY;
         end
         default: begin
            dec.emit = 1'b1;
            dec.kind = EV_UNKNOWN;
         end
      endcase
   end

endmodule

@@ rtl/companion_mcu_frame_receiver_top.sv @@
// Frame receiver top level: byte sequencer, buffer and event decoder.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_stall | req_rx_byte
//  rsp     | out       | rsp_valid/rsp_stall | rsp_event_kind .. rsp_battery_chemistry
//  csr     | in        | csr_we              | csr_wdata (landscape_mode)
//
// One byte is accepted while idle, then scan passes run until no complete frame is left.
// A pass tests the lead byte (the pass ends at once when the buffer is empty), searches
// byte by byte for a start byte, walks header and checksum through the single buffer
// read port, decodes, and puts out at most one event.
// req_stall stays high until the scan passes end and the sequencer returns to idle.
// Synchronous reset clears counts, battery values and the mode; buffer
// contents are unknown until written. A stalled event holds the sequencer.
module companion_mcu_frame_receiver_top #(
   parameter int FRAME_BUF_BYTES      = cmfr_pkg::FRAME_BUF_BYTES_DEF,
   parameter int TOUCH_SETTLE_SAMPLES = cmfr_pkg::TOUCH_SETTLE_SAMPLES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [3:0]  rsp_msg_type,
   output logic [3:0]  rsp_payload_len,
   output logic [15:0] rsp_key_code,
   output logic [5:0]  rsp_button_mask,
   output logic        rsp_button_released,
   output logic [15:0] rsp_pen_x,
   output logic [15:0] rsp_pen_y,
   output logic [7:0]  rsp_ac_status,
   output logic [15:0] rsp_battery_voltage,
   output logic [7:0]  rsp_battery_status,
   output logic [7:0]  rsp_battery_chemistry,
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import cmfr_pkg::*;

   localparam int N  = FRAME_BUF_BYTES;
   localparam int AW = $clog2(N);
   localparam int CW = $clog2(N + 2);

   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    hdr_ff, hdr_in;
   logic [7:0]    pay_ff [5];
   logic [7:0]    pay_in [5];
   logic [2:0]    k_ff, k_in;
   logic [3:0]    touch_ff, touch_in;
   logic [7:0]    ac_ff, ac_in;
   logic [15:0]   volt_ff, volt_in;
   logic [7:0]    stat_ff, stat_in;
   logic [7:0]    chem_ff, chem_in;
   logic          land_ff;
   logic [2:0]    kind_ff, kind_in;
   logic [15:0]   key_ff, key_in;
   logic [5:0]    mask_ff, mask_in;
   logic          rel_ff, rel_in;
   logic [15:0]   x_ff, x_in;
   logic [15:0]   y_ff, y_in;

   logic          accept;
   logic [CW-1:0] wr_off;
   logic [7:0]    rd;
   logic [CW-1:0] j;
   logic [CW-1:0] pj;
   logic [CW-1:0] hdr_need;
   logic [CW-1:0] chk_at;
   logic [CW-1:0] frame_len;
   dec_type       dec;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] h, logic [CW-1:0] s);
      logic [CW:0] t;
      t = (CW+1)'(h) + (CW+1)'(s);
      if (t >= (CW+1)'(N)) begin
         t = t - (CW+1)'(N);
      end
      return t[AW-1:0];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign wr_off    = (count_ff >= CW'(N)) ? '0 : count_ff;
   assign j         = idx_ff - CW'(1);
   assign pj        = j - CW'(2);
   assign hdr_need  = CW'(rd[3:0]) + CW'(3);
   assign chk_at    = CW'(hdr_ff[3:0]) + CW'(2);
   assign frame_len = CW'(hdr_ff[3:0]) + CW'(3);

   cmfr_buf #(.N(N)) u_buf (
      .clock   (clock),
      .head    (head_ff),
      .wr_en   (accept),
      .wr_off  (wr_off),
      .wr_data (req_rx_byte),
      .rd_off  (idx_ff),
      .rd_data (rd)
   );

   cmfr_decode #(.SETTLE(TOUCH_SETTLE_SAMPLES)) u_decode (
      .hdr       (hdr_ff),
      .p0        (pay_ff[0]),
      .p1        (pay_ff[1]),
      .p2        (pay_ff[2]),
      .p3        (pay_ff[3]),
      .land      (land_ff),
      .touch_cnt (touch_ff),
      .dec       (dec)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_LOOP;
         ST_LOOP:   state_in = (count_ff == '0) ? ST_IDLE : ST_WAIT0;
         ST_WAIT0:  state_in = ST_TEST0;
         ST_TEST0: begin
            if (rd != START_BYTE) begin
               state_in = ST_SCAN;
            end else if (count_ff < CW'(3)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HDR;
            end
         end
         ST_SCAN: begin
            if (j >= count_ff) begin
               state_in = ST_IDLE;
            end else if (rd == START_BYTE) begin
               state_in = ST_LOOP;
            end
         end
         ST_HDR:    state_in = (count_ff < hdr_need) ? ST_IDLE : ST_SUM;
         ST_SUM: begin
            if (j == chk_at) begin
               state_in = (rd == sum_ff) ? ST_DECODE : ST_LOOP;
            end
         end
         ST_DECODE: state_in = (dec.emit && k_ff < MAX_RESULTS) ? ST_OUT : ST_LOOP;
         ST_OUT:    if (!rsp_stall) state_in = ST_LOOP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      hdr_in   = hdr_ff;
      pay_in   = pay_ff;
      k_in     = k_ff;
      touch_in = touch_ff;
      ac_in    = ac_ff;
      volt_in  = volt_ff;
      stat_in  = stat_ff;
      chem_in  = chem_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      mask_in  = mask_ff;
      rel_in   = rel_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = wr_off + CW'(1);
               k_in     = '0;
            end
         end
         ST_LOOP:  idx_in = '0;
         ST_WAIT0: idx_in = CW'(1);
         ST_TEST0: idx_in = CW'(2);
         ST_SCAN: begin
            if (j >= count_ff) begin
               count_in = '0;
            end else if (rd == START_BYTE) begin
               head_in  = wrap_add(head_ff, j);
               count_in = count_ff - j;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         ST_HDR: begin
            hdr_in = rd;
            sum_in = rd;
            idx_in = CW'(3);
         end
         ST_SUM: begin
            if (j == chk_at) begin
               // Bad checksum: drop the start byte and rescan.
               if (rd != sum_ff) begin
                  head_in  = wrap_add(head_ff, CW'(1));
                  count_in = count_ff - CW'(1);
               end
            end else begin
               sum_in = sum_ff + rd;
               idx_in = idx_ff + CW'(1);
               for (int i = 0; i < 5; i++) begin
                  if (pj == CW'(i)) pay_in[i] = rd;
               end
            end
         end
         ST_DECODE: begin
            head_in  = wrap_add(head_ff, frame_len);
            count_in = count_ff - frame_len;
            if (k_ff < MAX_RESULTS) begin
               touch_in = dec.touch_next;
               if (dec.bat_load) begin
                  ac_in   = pay_ff[0];
                  chem_in = pay_ff[1];
                  volt_in = {pay_ff[3], pay_ff[2]};
                  stat_in = pay_ff[4];
               end
               if (dec.emit) begin
                  k_in    = k_ff + 3'd1;
                  kind_in = dec.kind;
                  key_in  = dec.key;
                  mask_in = dec.mask;
                  rel_in  = dec.rel;
                  x_in    = dec.x;
                  y_in    = dec.y;
               end
            end
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         k_ff     <= '0;
         touch_ff <= '0;
         ac_ff    <= '0;
         volt_ff  <= '0;
         stat_ff  <= '0;
         chem_ff  <= '0;
         land_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         k_ff     <= k_in;
         touch_ff <= touch_in;
         ac_ff    <= ac_in;
         volt_ff  <= volt_in;
         stat_ff  <= stat_in;
         chem_ff  <= chem_in;
         if (csr_we) land_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      hdr_ff  <= hdr_in;
      pay_ff  <= pay_in;
      kind_ff <= kind_in;
      key_ff  <= key_in;
      mask_ff <= mask_in;
      rel_ff  <= rel_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
   end

   assign rsp_event_kind        = kind_ff;
   assign rsp_msg_type          = hdr_ff[7:4];
   assign rsp_payload_len       = hdr_ff[3:0];
   assign rsp_key_code          = key_ff;
   assign rsp_button_mask       = mask_ff;
   assign rsp_button_released   = rel_ff;
   assign rsp_pen_x             = x_ff;
   assign rsp_pen_y             = y_ff;
   assign rsp_ac_status         = ac_ff;
   assign rsp_battery_voltage   = volt_ff;
   assign rsp_battery_status    = stat_ff;
   assign rsp_battery_chemistry = chem_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(N))
      else $error("buffer count exceeds depth");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff < AW'(N - 1) || head_ff == AW'(N - 1))
      else $error("head pointer out of range");

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= MAX_RESULTS)
      else $error("too many events for one byte");

   a_sum_in_buf: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> (j < count_ff))
      else $error("checksum walk past buffered bytes");

   a_out_from_decode: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DECODE)
      else $error("event raised outside decode");

endmodule
